FILE: hdl/qspd_pkg.sv
// shared types, constants and the quadrature step table for the speed loop
package qspd_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 10;
  localparam int PERIOD_W = 10;
  localparam int DIR_W    = 2;
  localparam int DUTY_W   = 7;
  localparam int DRIVE_W  = 2;
  localparam int POS_OUT_W = 32;
  localparam int IVAL_W   = 16;
  localparam int ERR_W    = 12;
  localparam int INTEG_W  = 40;
  localparam int SPLIT_W  = 20;
  localparam int MUL_A_W  = GAIN_W + 1;
  localparam int MUL_B_W  = SPLIT_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = PROD_W + SPLIT_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SPEED_MAX = 1023;
  localparam int DUTY_MAX  = 100;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd6;

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd13107;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = 16'd66;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 16'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 10'd50;

  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // direction request code for forward; any negative code means backward
  localparam logic [DIR_W-1:0] DIR_REQ_FWD = 2'b01;

  localparam logic [DRIVE_W-1:0] DRIVE_IDLE = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_FWD  = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_BACK = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop;
    logic [GAIN_W-1:0]   integ;
    logic [GAIN_W-1:0]   deriv;
    logic [PERIOD_W-1:0] period;
  } pid_gains_t;

  typedef struct packed {
    logic                    start;
    logic signed [ERR_W-1:0] err;
    logic                    out_free;
  } pid_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DUTY_W-1:0] duty;
  } pid_stat_t;

  // index is {cur_b, cur_a, prev_b, prev_a}
  function automatic logic signed [2:0] step_lut(input logic [3:0] idx);
    logic signed [2:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = 3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -3'sd1;
      4'd3, 4'd12:              s = 3'sd2;
      4'd6, 4'd9:               s = -3'sd2;
      default:                  s = 3'sd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/qspd_if.sv
// request channel interfaces for encoder input and duty results
interface qspd_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic pin_a;
  logic pin_b;
  modport source(output valid, output opcode, output pin_a, output pin_b, input ready);
  modport sink(input valid, input opcode, input pin_a, input pin_b, output ready);
endinterface

interface qspd_out_if;
  logic                             valid;
  logic                             ready;
  logic [qspd_pkg::DUTY_W-1:0]      duty;
  logic [qspd_pkg::DRIVE_W-1:0]     drive;
  logic [qspd_pkg::SPEED_W-1:0]     measured_speed;
  logic signed [qspd_pkg::POS_OUT_W-1:0] position;
  modport source(output valid, output duty, output drive, output measured_speed,
                 output position, input ready);
  modport sink(input valid, input duty, input drive, input measured_speed,
               input position, output ready);
endinterface

FILE: hdl/quadrature_speed_pid.sv
// quadrature encoder speed loop with a fixed-point pid, top level
//
// in_ch carries requests: opcode 0 is an encoder pin sample (pin_a, pin_b),
// opcode 1 is a sample tick that runs the controller. out_ch returns one
// result per tick: duty percent, bridge drive, measured speed and position.
// cfg_we/cfg_index/cfg_wdata write one of the seven control registers per cycle.
// a pin sample gives no result; ready stays high.
// after a tick is accepted, the pid sequencer runs the integral update and
// four gain products (the integral term in two halves) through one
// registered multiplier; in_ch.ready is low meanwhile, so no new request
// is taken until the tick has finished.
// results sit in an output register: while the receiver stalls, pin samples
// are still taken, and a following tick finishes its products but waits in
// its last step until the register frees.
// reset loads the register defaults and clears pin history, counts,
// integral and last error; no result is pending after reset.
module quadrature_speed_pid #(
  parameter int POSITION_WIDTH = qspd_pkg::POSITION_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = qspd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qspd_in_if.sink                           in_ch,
  qspd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [qspd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qspd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SPEED_W = qspd_pkg::SPEED_W;
  localparam int IVAL_W  = qspd_pkg::IVAL_W;

  logic [SPEED_W-1:0]              setpoint_r;
  logic [qspd_pkg::DIR_W-1:0]      dir_r;
  logic [qspd_pkg::GAIN_W-1:0]     prop_r, integ_r, deriv_r;
  logic [qspd_pkg::PERIOD_W-1:0]   period_r;
  logic                            invert_r;

  logic                            in_acc, pin_req, tick_req, out_free;
  logic signed [POSITION_WIDTH-1:0] pos;
  logic signed [IVAL_W-1:0]        ival;
  logic [IVAL_W-1:0]               ival_abs;
  logic [SPEED_W-1:0]              mag, mag_r, mag_nxt;
  logic [qspd_pkg::DRIVE_W-1:0]    drive;
  qspd_pkg::pid_gains_t            gains;
  qspd_pkg::pid_cmd_t              cmd;
  qspd_pkg::pid_stat_t             stat;

  logic                            out_valid_r, out_valid_nxt;
  logic [qspd_pkg::DUTY_W-1:0]     duty_r, duty_nxt;
  logic [qspd_pkg::DRIVE_W-1:0]    drive_r, drive_nxt;
  logic [SPEED_W-1:0]              speed_r, speed_nxt;
  logic signed [qspd_pkg::POS_OUT_W-1:0] pos_out_r, pos_out_nxt;

  assign in_ch.ready = !stat.busy;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign pin_req  = in_acc && (in_ch.opcode == qspd_pkg::OP_PIN);
  assign tick_req = in_acc && (in_ch.opcode == qspd_pkg::OP_TICK);
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      dir_r      <= '0;
      prop_r     <= qspd_pkg::PROP_GAIN_RST;
      integ_r    <= qspd_pkg::INTEG_GAIN_RST;
      deriv_r    <= qspd_pkg::DERIV_GAIN_RST;
      period_r   <= qspd_pkg::PERIOD_RST;
      invert_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qspd_pkg::REG_SETPOINT:   setpoint_r <= cfg_wdata[SPEED_W-1:0];
        qspd_pkg::REG_DIRECTION:  dir_r      <= cfg_wdata[qspd_pkg::DIR_W-1:0];
        qspd_pkg::REG_PROP_GAIN:  prop_r     <= cfg_wdata;
        qspd_pkg::REG_INTEG_GAIN: integ_r    <= cfg_wdata;
        qspd_pkg::REG_DERIV_GAIN: deriv_r    <= cfg_wdata;
        qspd_pkg::REG_PERIOD:     period_r   <= cfg_wdata[qspd_pkg::PERIOD_W-1:0];
        qspd_pkg::REG_INVERT:     invert_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  qspd_encoder #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_encoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (pin_req),
    .pin_a  (in_ch.pin_a),
    .pin_b  (in_ch.pin_b),
    .invert (invert_r),
    .clear  (tick_req),
    .pos    (pos),
    .ival   (ival)
  );

  always_comb begin
    ival_abs = ival[IVAL_W-1] ? IVAL_W'(-ival) : IVAL_W'(ival);
    mag = (ival_abs > IVAL_W'(qspd_pkg::SPEED_MAX)) ? SPEED_W'(qspd_pkg::SPEED_MAX)
                                                    : ival_abs[SPEED_W-1:0];
    mag_nxt = tick_req ? mag : mag_r;
  end

  assign gains.prop   = prop_r;
  assign gains.integ  = integ_r;
  assign gains.deriv  = deriv_r;
  assign gains.period = period_r;

  assign cmd.start    = tick_req;
  assign cmd.err      = $signed({2'b00, setpoint_r}) - $signed({2'b00, mag});
  assign cmd.out_free = out_free;

  qspd_pid #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pid (
    .clk   (clk),
    .rst_n (rst_n),
    .gains (gains),
    .cmd   (cmd),
    .stat  (stat)
  );

  always_comb begin
    priority if (dir_r == qspd_pkg::DIR_REQ_FWD) drive = qspd_pkg::DRIVE_FWD;
    else if (dir_r[1])                           drive = qspd_pkg::DRIVE_BACK;
    else                                         drive = qspd_pkg::DRIVE_IDLE;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    duty_nxt      = duty_r;
    drive_nxt     = drive_r;
    speed_nxt     = speed_r;
    pos_out_nxt   = pos_out_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (stat.done && out_free) begin
      out_valid_nxt = 1'b1;
      duty_nxt      = (drive == qspd_pkg::DRIVE_IDLE) ? '0 : stat.duty;
      drive_nxt     = drive;
      speed_nxt     = mag_r;
      pos_out_nxt   = qspd_pkg::POS_OUT_W'(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    duty_r    <= duty_nxt;
    drive_r   <= drive_nxt;
    speed_r   <= speed_nxt;
    pos_out_r <= pos_out_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.duty           = duty_r;
  assign out_ch.drive          = drive_r;
  assign out_ch.measured_speed = speed_r;
  assign out_ch.position       = pos_out_r;

  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tick_req |=> (ival == '0))
    else $error("interval count not cleared after tick");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_ch.ready)
    else $error("request taken while controller busy");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (duty_r <= qspd_pkg::DUTY_W'(qspd_pkg::DUTY_MAX)))
    else $error("duty out of range");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (drive_r == qspd_pkg::DRIVE_IDLE)) |-> (duty_r == '0))
    else $error("idle drive with nonzero duty");

endmodule

FILE: hdl/qspd_encoder.sv
// quadrature decoder with wrapping position and saturating interval count
module qspd_encoder #(
  parameter int POSITION_WIDTH = qspd_pkg::POSITION_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              sample,
  input  logic                              pin_a,
  input  logic                              pin_b,
  input  logic                              invert,
  input  logic                              clear,
  output logic signed [POSITION_WIDTH-1:0]  pos,
  output logic signed [qspd_pkg::IVAL_W-1:0] ival
);

  logic [1:0]                           prev_r, prev_nxt;
  logic signed [POSITION_WIDTH-1:0]     pos_r, pos_nxt;
  logic signed [qspd_pkg::IVAL_W-1:0]   ival_r, ival_nxt;
  logic signed [2:0]                    step_raw, step_adj;
  logic signed [qspd_pkg::IVAL_W:0]     ival_sum;

  always_comb begin
    step_raw = qspd_pkg::step_lut({pin_b, pin_a, prev_r});
    step_adj = invert ? -step_raw : step_raw;
    ival_sum = (qspd_pkg::IVAL_W+1)'(ival_r) + (qspd_pkg::IVAL_W+1)'(step_adj);
    prev_nxt = prev_r;
    pos_nxt  = pos_r;
    ival_nxt = ival_r;
    if (sample) begin
      prev_nxt = {pin_b, pin_a};
      pos_nxt  = pos_r + POSITION_WIDTH'(step_adj);
      if (ival_sum[qspd_pkg::IVAL_W] != ival_sum[qspd_pkg::IVAL_W-1]) begin
        ival_nxt = ival_sum[qspd_pkg::IVAL_W] ? {1'b1, {(qspd_pkg::IVAL_W-1){1'b0}}}
                                              : {1'b0, {(qspd_pkg::IVAL_W-1){1'b1}}};
      end else begin
        ival_nxt = ival_sum[qspd_pkg::IVAL_W-1:0];
      end
    end else if (clear) begin
      ival_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pos_r  <= '0;
      ival_r <= '0;
    end else begin
      prev_r <= prev_nxt;
      pos_r  <= pos_nxt;
      ival_r <= ival_nxt;
    end
  end

  assign pos  = pos_r;
  assign ival = ival_r;

endmodule

FILE: hdl/qspd_mul.sv
// shared registered multiplier, unsigned gain by signed operand
module qspd_mul (
  input  logic                                 clk,
  input  logic [qspd_pkg::GAIN_W-1:0]          op_a,
  input  logic signed [qspd_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [qspd_pkg::PROD_W-1:0]   prod
);

  logic signed [qspd_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, op_a}) * op_b;
  end

  assign prod = prod_r;

endmodule

FILE: hdl/qspd_pid.sv
// pid sequencer: integral update and gain products through one multiplier
module qspd_pid #(
  parameter int GAIN_FRAC_BITS = qspd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qspd_pkg::pid_gains_t gains,
  input  qspd_pkg::pid_cmd_t   cmd,
  output qspd_pkg::pid_stat_t  stat
);

  localparam int ACC_W   = qspd_pkg::ACC_W;
  localparam int ERR_W   = qspd_pkg::ERR_W;
  localparam int INTEG_W = qspd_pkg::INTEG_W;
  localparam int SPLIT_W = qspd_pkg::SPLIT_W;
  localparam int MUL_B_W = qspd_pkg::MUL_B_W;
  localparam int PROD_W  = qspd_pkg::PROD_W;
  localparam logic signed [ACC_W-1:0] DUTY_LIMIT =
    ACC_W'(qspd_pkg::DUTY_MAX) <<< GAIN_FRAC_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_I = 3'd1;
  localparam logic [2:0] S_SAT_I = 3'd2;
  localparam logic [2:0] S_ACC_P = 3'd3;
  localparam logic [2:0] S_ACC_D = 3'd4;
  localparam logic [2:0] S_ACC_L = 3'd5;
  localparam logic [2:0] S_ACC_H = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic signed [ERR_W-1:0]     err_r, err_nxt;
  logic signed [ERR_W-1:0]     diff_r, diff_nxt;
  logic signed [ERR_W-1:0]     last_r, last_nxt;
  logic signed [INTEG_W-1:0]   integ_r, integ_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [INTEG_W:0]     integ_sum;
  logic [qspd_pkg::GAIN_W-1:0] op_a;
  logic signed [MUL_B_W-1:0]   op_b;
  logic signed [PROD_W-1:0]    prod;
  logic [qspd_pkg::DUTY_W-1:0] duty;

  qspd_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_MUL_I: begin
        op_a = qspd_pkg::GAIN_W'(gains.period);
        op_b = MUL_B_W'(err_r);
      end
      S_SAT_I: begin
        op_a = gains.prop;
        op_b = MUL_B_W'(err_r);
      end
      S_ACC_P: begin
        op_a = gains.deriv;
        op_b = MUL_B_W'(diff_r);
      end
      S_ACC_D: begin
        op_a = gains.integ;
        op_b = $signed({1'b0, integ_r[SPLIT_W-1:0]});
      end
      S_ACC_L: begin
        op_a = gains.integ;
        op_b = MUL_B_W'($signed(integ_r[INTEG_W-1:SPLIT_W]));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(prod);
    state_nxt = state_r;
    err_nxt   = err_r;
    diff_nxt  = diff_r;
    last_nxt  = last_r;
    integ_nxt = integ_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          err_nxt   = cmd.err;
          diff_nxt  = cmd.err - last_r;
          last_nxt  = cmd.err;
          state_nxt = S_MUL_I;
        end
      end
      S_MUL_I: state_nxt = S_SAT_I;
      S_SAT_I: begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
          integ_nxt = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
          integ_nxt = integ_sum[INTEG_W-1:0];
        end
        state_nxt = S_ACC_P;
      end
      S_ACC_P: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = S_ACC_D;
      end
      S_ACC_D: begin
        acc_nxt   = acc_r + ACC_W'(prod);
        state_nxt = S_ACC_L;
      end
      S_ACC_L: begin
        acc_nxt   = acc_r + ACC_W'(prod);
        state_nxt = S_ACC_H;
      end
      S_ACC_H: begin
        acc_nxt   = acc_r + (ACC_W'(prod) <<< SPLIT_W);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (acc_r[ACC_W-1]) begin
      duty = '0;
    end else if (acc_r >= DUTY_LIMIT) begin
      duty = qspd_pkg::DUTY_W'(qspd_pkg::DUTY_MAX);
    end else begin
      duty = acc_r[GAIN_FRAC_BITS +: qspd_pkg::DUTY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= '0;
      integ_r <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    diff_r <= diff_nxt;
    acc_r  <= acc_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign stat.duty = duty;

endmodule
